@@ rtl/core/csvt_pkg.sv @@
// Shared types and constants for the CSV field tokenizer.
// Used by every module under rtl/core; no dependencies of its own.
`default_nettype none

package csvt_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
    localparam int unsigned MAX_RESULTS         = 3;

    localparam logic [7:0] SEPARATOR_RESET   = 8'd44;
    localparam logic [6:0] MAX_COLUMNS_RESET = 7'd100;
    localparam logic [9:0] MAX_ROWS_RESET    = 10'd1000;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [9:0] ROW_LIMIT = 10'h3FF;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SEPARATOR   = 2'd0,
        CFG_MAX_COLUMNS = 2'd1,
        CFG_MAX_ROWS    = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        REQ_BYTE = 2'b0,
        REQ_END  = 2'b1
    } req_code_t;

    typedef enum logic [1:0] {
        TOK_BYTE     = 2'd0,
        TOK_CELL_END = 2'd1,
        TOK_ROW_END  = 2'd2,
        TOK_DONE     = 2'd3
    } token_kind_t;

    typedef struct packed {
        token_kind_t kind;
        logic [7:0]  data;
        logic [6:0]  col;
        logic [9:0]  row;
        logic        clp;
    } result_t;

    // all results caused by one input item, in order; cnt of them are valid
    typedef struct packed {
        logic [1:0]                cnt;
        result_t [MAX_RESULTS-1:0] res;
    } bundle_t;

    function automatic result_t make_result(token_kind_t kind, logic [7:0] data,
                                            logic [6:0] col, logic [9:0] row,
                                            logic clp);
        result_t r;
        r.kind = kind;
        r.data = data;
        r.col  = col;
        r.row  = row;
        r.clp  = clp;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/csv_field_tokenizer_core.sv @@
// CSV field tokenizer top level: streams document bytes in, cell tokens out.
// Uses csvt_pkg, csvt_front, csvt_queue and csvt_back.
//
// Input channel req_valid/req_ready carries one document byte (req_type 0)
// or an end-of-document mark (req_type 1). Output channel tok_valid/tok_ready
// carries tokens: cell byte, cell end, row end and done, each with column,
// row, clipped flag and last_of_run on the final token of an input item.
// Configuration: cfg_we writes cfg_data to register cfg_index (separator,
// max_columns, max_rows) at the clock edge; the user must write only while the block is idle (not enforced).
//
// The front end decides each byte in the cycle it is transferred and queues
// the whole set of tokens it causes; while tok_ready is high the back end
// delivers one token a cycle through the output register. The first token of
// an item is written into the queue at its transfer and then loaded into the
// output register before it is valid. One item per cycle is sustained while
// tok_ready is high and items cause at most one token; an item causing two or
// three tokens holds the output register until each has gone out, and the
// queue (QUEUE_DEPTH items) absorbs such bursts before req_ready drops.
// When tok_ready is low the output token holds, the queue fills, and then
// req_ready goes low. Reset clears the parse state, empties the queue and
// restores separator 44, max_columns 100 and max_rows 1000.
`default_nettype none

module csv_field_tokenizer_core #(
    parameter int unsigned QUEUE_DEPTH = csvt_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [csvt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [csvt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             req_valid,
    output logic                                  req_ready,
    input  wire logic                             req_type,
    input  wire logic [7:0]                       byte_value,
    output logic                                  tok_valid,
    input  wire logic                             tok_ready,
    output logic [1:0]                            token_kind,
    output logic [7:0]                            cell_byte,
    output logic [6:0]                            column_index,
    output logic [9:0]                            row_index,
    output logic                                  clipped,
    output logic                                  last_of_run
);
    import csvt_pkg::*;

    logic    queue_full;
    logic    queue_empty;
    logic    push;
    logic    pop;
    bundle_t push_bundle;
    bundle_t head;

    csvt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .byte_value  (byte_value),
        .queue_full  (queue_full),
        .push        (push),
        .push_bundle (push_bundle)
    );

    csvt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (push_bundle),
        .full        (queue_full),
        .pop         (pop),
        .empty       (queue_empty),
        .head        (head)
    );

    csvt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (queue_empty),
        .pop          (pop),
        .tok_valid    (tok_valid),
        .tok_ready    (tok_ready),
        .token_kind   (token_kind),
        .cell_byte    (cell_byte),
        .column_index (column_index),
        .row_index    (row_index),
        .clipped      (clipped),
        .last_of_run  (last_of_run)
    );

endmodule

`default_nettype wire

@@ rtl/core/csvt_front.sv @@
// Front end: accepts document bytes, holds parse state and configuration,
// and builds one result bundle per item. Depends on csvt_pkg.
`default_nettype none

module csvt_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [csvt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [csvt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire logic                          req_type,
    input  wire logic [7:0]                    byte_value,
    input  wire logic                          queue_full,
    output logic                               push,
    output csvt_pkg::bundle_t                  push_bundle
);
    import csvt_pkg::*;

    logic [7:0] sep_reg;
    logic [6:0] max_cols_reg;
    logic [9:0] max_rows_reg;

    logic       in_quotes_reg, in_quotes_next;
    logic       quote_pend_reg, quote_pend_next;
    logic       nonempty_reg, nonempty_next;
    logic [6:0] col_reg, col_next;
    logic [9:0] row_reg, row_next;
    logic       stopped_reg, stopped_next;
    logic       clipped_reg, clipped_next;

    logic    accept;
    bundle_t bundle;

    assign req_ready   = !queue_full;
    assign accept      = req_valid && req_ready;
    assign push        = accept && (bundle.cnt != 2'd0);
    assign push_bundle = bundle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg      <= SEPARATOR_RESET;
            max_cols_reg <= MAX_COLUMNS_RESET;
            max_rows_reg <= MAX_ROWS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SEPARATOR:   sep_reg      <= cfg_data[7:0];
                CFG_MAX_COLUMNS: max_cols_reg <= cfg_data[6:0];
                CFG_MAX_ROWS:    max_rows_reg <= cfg_data[9:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        logic do_content;
        logic do_cell_end;
        logic do_row_end;
        logic do_done;
        logic handled;
        logic [1:0] n;

        in_quotes_next  = in_quotes_reg;
        quote_pend_next = quote_pend_reg;
        nonempty_next   = nonempty_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        stopped_next    = stopped_reg;
        clipped_next    = clipped_reg;
        do_content      = 1'b0;
        do_cell_end     = 1'b0;
        do_row_end      = 1'b0;
        do_done         = 1'b0;
        handled         = 1'b0;
        n               = 2'd0;
        bundle          = '0;

        // classify the item
        if (req_type == REQ_END[0])
        begin
            if (quote_pend_next)
            begin
                quote_pend_next = 1'b0;
                in_quotes_next  = 1'b0;
            end
            if (!stopped_reg && (nonempty_reg || col_reg != 7'd0))
            begin
                do_cell_end = 1'b1;
                do_row_end  = 1'b1;
            end
            do_done = 1'b1;
        end
        else if (stopped_reg)
        begin
            clipped_next = 1'b1;
        end
        else
        begin
            if (quote_pend_reg)
            begin
                quote_pend_next = 1'b0;
                if (byte_value == CH_QUOTE)
                begin
                    // doubled quote: one literal quote
                    do_content = 1'b1;
                    handled    = 1'b1;
                end
                else
                begin
                    in_quotes_next = 1'b0;
                end
            end
            if (!handled)
            begin
                if (byte_value == CH_QUOTE)
                begin
                    if (in_quotes_next)
                        quote_pend_next = 1'b1;
                    else if (!nonempty_reg)
                        in_quotes_next = 1'b1;
                    else
                        do_content = 1'b1;
                end
                else if (!in_quotes_next && (byte_value == sep_reg || byte_value == CH_LF))
                begin
                    do_cell_end = 1'b1;
                    do_row_end  = (byte_value == CH_LF);
                end
                else if (byte_value != CH_CR || in_quotes_next)
                begin
                    do_content = 1'b1;
                end
            end
        end

        // carry out the actions in order, collecting results
        if (do_content)
        begin
            nonempty_next = 1'b1;
            if (col_next < max_cols_reg)
            begin
                bundle.res[n] = make_result(TOK_BYTE, byte_value, col_next, row_next,
                                            clipped_next);
                n = n + 2'd1;
            end
        end
        if (do_cell_end)
        begin
            if (col_next < max_cols_reg)
            begin
                bundle.res[n] = make_result(TOK_CELL_END, 8'd0, col_next, row_next,
                                            clipped_next);
                n        = n + 2'd1;
                col_next = col_next + 7'd1;
            end
            else
            begin
                clipped_next = 1'b1;
            end
            nonempty_next = 1'b0;
        end
        if (do_row_end)
        begin
            bundle.res[n] = make_result(TOK_ROW_END, 8'd0, col_next, row_next, clipped_next);
            n        = n + 2'd1;
            col_next = 7'd0;
            if (row_next != ROW_LIMIT)
                row_next = row_next + 10'd1;
            if (row_next >= max_rows_reg)
                stopped_next = 1'b1;
        end
        if (do_done)
        begin
            bundle.res[n] = make_result(TOK_DONE, 8'd0, 7'd0, row_next, clipped_next);
            n = n + 2'd1;
            // start afresh for the next document
            in_quotes_next  = 1'b0;
            quote_pend_next = 1'b0;
            nonempty_next   = 1'b0;
            col_next        = 7'd0;
            row_next        = 10'd0;
            stopped_next    = 1'b0;
            clipped_next    = 1'b0;
        end
        bundle.cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quotes_reg  <= 1'b0;
            quote_pend_reg <= 1'b0;
            nonempty_reg   <= 1'b0;
            col_reg        <= 7'd0;
            row_reg        <= 10'd0;
            stopped_reg    <= 1'b0;
            clipped_reg    <= 1'b0;
        end
        else if (accept)
        begin
            in_quotes_reg  <= in_quotes_next;
            quote_pend_reg <= quote_pend_next;
            nonempty_reg   <= nonempty_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            stopped_reg    <= stopped_next;
            clipped_reg    <= clipped_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/csvt_queue.sv @@
// Short bundle queue between the front and back ends.
// Depends on csvt_pkg for the bundle type.
`default_nettype none

module csvt_queue #(
    parameter int unsigned DEPTH = csvt_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  csvt_pkg::bundle_t      push_bundle,
    output logic                   full,
    input  wire logic              pop,
    output logic                   empty,
    output csvt_pkg::bundle_t      head
);
    import csvt_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    bundle_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_bundle;
    end

endmodule

`default_nettype wire

@@ rtl/core/csvt_back.sv @@
// Back end: walks the head bundle one result per cycle into the output register, unless tok_ready stalls it.
// Depends on csvt_pkg for the bundle and result types.
`default_nettype none

module csvt_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  csvt_pkg::bundle_t  head,
    input  wire logic          empty,
    output logic               pop,
    output logic               tok_valid,
    input  wire logic          tok_ready,
    output logic [1:0]         token_kind,
    output logic [7:0]         cell_byte,
    output logic [6:0]         column_index,
    output logic [9:0]         row_index,
    output logic               clipped,
    output logic               last_of_run
);
    import csvt_pkg::*;

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    result_t    res_reg, res_next;
    logic       last_reg, last_next;
    logic       load;
    logic       is_last;

    assign load    = !empty && (!valid_reg || tok_ready);
    assign is_last = (idx_reg == head.cnt - 2'd1);
    assign pop     = load && is_last;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        res_next   = res_reg;
        last_next  = last_reg;
        if (valid_reg && tok_ready)
            valid_next = 1'b0;
        if (load)
        begin
            valid_next = 1'b1;
            res_next   = head.res[idx_reg];
            last_next  = is_last;
            // advance within the bundle, rewind when it is used up
            idx_next   = is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        last_reg <= last_next;
    end

    assign tok_valid    = valid_reg;
    assign token_kind   = res_reg.kind;
    assign cell_byte    = res_reg.data;
    assign column_index = res_reg.col;
    assign row_index    = res_reg.row;
    assign clipped      = res_reg.clp;
    assign last_of_run  = last_reg;

endmodule

`default_nettype wire
